// ===== design/ffa_pkg.sv =====
// Shared constants and codes for the first-fit allocator.
package ffa_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int SIZE_BITS_DEF  = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  // spare opcode, handled as a query
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== design/ffa_cfg_if.sv =====
// Configuration write channel carrying the total size.
interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_size;
  modport source (output valid, output total_size, input ready);
  modport sink   (input valid, input total_size, output ready);
endinterface

// ===== design/ffa_req_if.sv =====
// Request channel: one allocator operation per item.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] owner_id;
  logic [31:0] request_size;
  modport source (output valid, output opcode, output owner_id, output request_size,
                  input ready);
  modport sink   (input valid, input opcode, input owner_id, input request_size,
                  output ready);
endinterface

// ===== design/ffa_rsp_if.sv =====
// Response channel: one result item per operation.
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        resident;
  logic [6:0]  used_count;
  logic [31:0] free_bytes;
  modport source (output valid, output status, output resident, output used_count,
                  output free_bytes, input ready);
  modport sink   (input valid, input status, input resident, input used_count,
                  input free_bytes, output ready);
endinterface

// ===== design/first_fit_allocator.sv =====
// First-fit allocator with an ordered block table held in one memory.
//
// The block table (base, size, used, owner) sits in a memory of MAX_BLOCKS entries
// with one write and one registered read port; a small sequencer walks it entry by
// entry. Allocate scans to the first fitting free block, shifts the tail up on a
// split (or reports full when the table has no spare entry), then scans for
// residency. Free scans for the owner, runs one compaction pass over the whole table
// merging free runs, then scans for residency. Query passes through the scan states
// once and then runs one residency scan. A new request is taken only in idle, after
// the previous response has been registered. Writing total_size rebuilds the table
// as one free block. Used count and free bytes are kept as running totals.
module first_fit_allocator #(
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = ffa_pkg::SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ffa_cfg_if.sink   cfg,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SB = SIZE_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_EXACT    = 4'd4;
  localparam logic [3:0] S_SHIFT_RD = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_SPLIT_HI = 4'd7;
  localparam logic [3:0] S_SPLIT_LO = 4'd8;
  localparam logic [3:0] S_MRG_RD   = 4'd9;
  localparam logic [3:0] S_MRG_USE  = 4'd10;
  localparam logic [3:0] S_MRG_LAST = 4'd11;
  localparam logic [3:0] S_RES_RD   = 4'd12;
  localparam logic [3:0] S_RES_CHK  = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  typedef struct packed {
    logic [SB-1:0] base;
    logic [SB-1:0] size;
    logic          used;
    logic [15:0]   owner;
  } entry_t;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata, wdata, acc, fent, ment;
  logic [IW-1:0] raddr, waddr;
  logic          we;

  logic [3:0]    state;
  logic [SB-1:0] total, freeb, req_size;
  logic [CW-1:0] cnt, used_cnt;
  logic [1:0]    op, status;
  logic [15:0]   who;
  logic [IW-1:0] idx, widx, fidx;
  logic          acc_v, resident;
  logic          is_last, merge_run, qmode;

  logic [SB+31:0] cfg_ext, req_ext;
  logic [SB+31:0] fb_ext;
  logic [CW+6:0]  uc_ext;

  logic [1:0]  rsp_status;
  logic        rsp_resident;
  logic [6:0]  rsp_used;
  logic [31:0] rsp_free;
  logic        rsp_valid;

  assign cfg_ext = {32'b0, {SB{1'b0}}} | (SB + 32)'(cfg.total_size);
  assign req_ext = {32'b0, {SB{1'b0}}} | (SB + 32)'(req.request_size);
  assign fb_ext  = (SB + 32)'(freeb);
  assign uc_ext  = (CW + 7)'(used_cnt);

  assign is_last   = (CW'(idx) == cnt - CW'(1));
  assign merge_run = acc_v && !acc.used && !ment.used;
  assign qmode     = (op != ffa_pkg::OP_ALLOC) && (op != ffa_pkg::OP_FREE);

  // entry being merged, with the freed block shown as free
  always_comb begin
    ment = rdata;
    if (idx == fidx) begin
      ment.used  = 1'b0;
      ment.owner = 16'd0;
    end
  end

  always_comb begin
    raddr = idx;
    we    = 1'b0;
    waddr = idx;
    wdata = acc;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {{SB{1'b0}}, total, 1'b0, 16'd0};
      end
      S_SHIFT_RD: raddr = idx - IW'(1);
      S_SHIFT_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_EXACT: begin
        we    = 1'b1;
        waddr = fidx;
        wdata = {fent.base, fent.size, 1'b1, who};
      end
      S_SPLIT_HI: begin
        we    = 1'b1;
        waddr = fidx + IW'(1);
        wdata = {fent.base + req_size, fent.size - req_size, 1'b0, 16'd0};
      end
      S_SPLIT_LO: begin
        we    = 1'b1;
        waddr = fidx;
        wdata = {fent.base, req_size, 1'b1, who};
      end
      S_MRG_USE: begin
        we    = acc_v && !merge_run;
        waddr = widx;
      end
      S_MRG_LAST: begin
        we    = 1'b1;
        waddr = widx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      total     <= '0;
      freeb     <= '0;
      cnt       <= CW'(1);
      used_cnt  <= '0;
      rsp_valid <= 1'b0;
      acc_v     <= 1'b0;
    end else begin
      // S_OUT handles the output register itself
      if (rsp_valid && rsp.ready && state != S_OUT) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            total    <= cfg_ext[SB-1:0];
            freeb    <= cfg_ext[SB-1:0];
            cnt      <= CW'(1);
            used_cnt <= '0;
            state    <= S_INIT;
          end else if (req.valid) begin
            op       <= req.opcode;
            who      <= req.owner_id;
            req_size <= req_ext[SB-1:0];
            idx      <= '0;
            status   <= ffa_pkg::ST_DONE;
            state    <= S_SCAN_RD;
          end
        end
        S_INIT: state <= S_IDLE;
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (op == ffa_pkg::OP_ALLOC) begin
            if (!rdata.used && rdata.size >= req_size) begin
              fent <= rdata;
              fidx <= idx;
              if (rdata.size == req_size) begin
                state <= S_EXACT;
              end else if (cnt == CW'(MAX_BLOCKS)) begin
                status <= ffa_pkg::ST_FULL;
                idx    <= '0;
                state  <= S_RES_RD;
              end else begin
                idx <= cnt[IW-1:0];
                if (cnt == CW'(idx) + CW'(1)) state <= S_SPLIT_HI;
                else                          state <= S_SHIFT_RD;
              end
            end else if (is_last) begin
              status <= ffa_pkg::ST_NO_FIT;
              idx    <= '0;
              state  <= S_RES_RD;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end else if (op == ffa_pkg::OP_FREE) begin
            if (rdata.used && rdata.owner == who) begin
              fidx     <= idx;
              freeb    <= freeb + rdata.size;
              used_cnt <= used_cnt - CW'(1);
              idx      <= '0;
              widx     <= '0;
              acc_v    <= 1'b0;
              state    <= S_MRG_RD;
            end else if (is_last) begin
              status <= ffa_pkg::ST_NOT_FOUND;
              idx    <= '0;
              state  <= S_RES_RD;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            // query: residency scan gives the answer
            idx   <= '0;
            state <= S_RES_RD;
          end
        end
        S_EXACT: begin
          used_cnt <= used_cnt + CW'(1);
          freeb    <= freeb - req_size;
          idx      <= '0;
          state    <= S_RES_RD;
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx <= idx - IW'(1);
          if (CW'(idx) == CW'(fidx) + CW'(2)) state <= S_SPLIT_HI;
          else                                state <= S_SHIFT_RD;
        end
        S_SPLIT_HI: state <= S_SPLIT_LO;
        S_SPLIT_LO: begin
          cnt      <= cnt + CW'(1);
          used_cnt <= used_cnt + CW'(1);
          freeb    <= freeb - req_size;
          idx      <= '0;
          state    <= S_RES_RD;
        end
        S_MRG_RD: state <= S_MRG_USE;
        S_MRG_USE: begin
          acc_v <= 1'b1;
          if (merge_run) begin
            acc.size <= acc.size + ment.size;
          end else begin
            acc <= ment;
            if (acc_v) widx <= widx + IW'(1);
          end
          if (is_last) begin
            state <= S_MRG_LAST;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_MRG_RD;
          end
        end
        S_MRG_LAST: begin
          cnt   <= CW'(widx) + CW'(1);
          acc_v <= 1'b0;
          idx   <= '0;
          state <= S_RES_RD;
        end
        S_RES_RD: state <= S_RES_CHK;
        S_RES_CHK: begin
          if (rdata.used && rdata.owner == who) begin
            resident <= 1'b1;
            state    <= S_OUT;
          end else if (is_last) begin
            resident <= 1'b0;
            state    <= S_OUT;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RES_RD;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_status   <= qmode ? (resident ? ffa_pkg::ST_DONE : ffa_pkg::ST_NOT_FOUND)
                                  : status;
            rsp_resident <= resident;
            rsp_used     <= uc_ext[6:0];
            rsp_free     <= fb_ext[31:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.resident   = rsp_resident;
  assign rsp.used_count = rsp_used;
  assign rsp.free_bytes = rsp_free;

endmodule
